FILE: rtl/pse_pkg.sv
// Package for the program stream video extractor: word types, start codes,
// parse phases and status codes. No dependencies.
package pse_pkg;

    // Width of the saturating payload counter.
    localparam int COUNT_BITS = 24;

    // Start codes 00 00 01 xx as they appear in the 32-bit shift register.
    localparam logic [31:0] SC_PACK  = 32'h0000_01BA;
    localparam logic [31:0] SC_SYS   = 32'h0000_01BB;
    localparam logic [31:0] SC_MAP   = 32'h0000_01BC;
    localparam logic [31:0] SC_VIDEO = 32'h0000_01E0;
    localparam logic [31:0] SC_AUDIO = 32'h0000_01C0;

    // Byte of the pack header that carries the stuffing length.
    localparam logic [3:0] PACK_STUFF_POS  = 4'd13;
    localparam logic [2:0] PACK_STUFF_MASK = 3'd7;

    // Header byte positions inside a structure.
    localparam logic [3:0] HIDX_CODE_LAST = 4'd3;
    localparam logic [3:0] HIDX_LEN_HI    = 4'd4;
    localparam logic [3:0] HIDX_LEN_LO    = 4'd5;
    localparam logic [3:0] HIDX_HDR_LEN   = 4'd8;

    // Frame types.
    localparam logic [1:0] FRAME_NONE = 2'd0;
    localparam logic [1:0] FRAME_P    = 2'd1;
    localparam logic [1:0] FRAME_I    = 2'd2;

    // Stop status codes.
    localparam logic [1:0] STOP_NONE    = 2'd0;
    localparam logic [1:0] STOP_UNKNOWN = 2'd1;
    localparam logic [1:0] STOP_BAD_LEN = 2'd2;

    typedef enum logic [7:0] {
        PH_CODE  = 8'b0000_0001,
        PH_PACK  = 8'b0000_0010,
        PH_LEN   = 8'b0000_0100,
        PH_PES   = 8'b0000_1000,
        PH_HSKIP = 8'b0001_0000,
        PH_PAY   = 8'b0010_0000,
        PH_SKIP  = 8'b0100_0000,
        PH_HALT  = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_valid;
        logic        done_res;
        logic [1:0]  frame_type;
        logic [23:0] body_length;
        logic [1:0]  stop_status;
    } t_out_word;

endpackage

FILE: rtl/pse_parser.sv
// Parse state and next-state logic of the program stream extractor.
// Depends on pse_pkg.
module pse_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  pse_pkg::t_in_word  i_word,
    output logic               o_produce,
    output pse_pkg::t_out_word o_result
);
    import pse_pkg::*;

    t_phase                r_phase,   n_phase;
    logic [31:0]           r_code,    n_code;
    logic [3:0]            r_hidx,    n_hidx;
    logic [15:0]           r_skip,    n_skip;
    logic [15:0]           r_plen,    n_plen;
    logic [1:0]            r_frame,   n_frame;
    logic [COUNT_BITS-1:0] r_count,   n_count;
    logic [1:0]            r_halt,    n_halt;

    logic                  w_emit;
    logic [7:0]            w_b;
    logic [2:0]            w_stuff;
    logic [16:0]           w_need;
    logic [15:0]           w_rem;

    assign w_b     = i_word.in_byte;
    assign w_stuff = w_b[2:0] & PACK_STUFF_MASK;
    assign w_need  = 17'd3 + 17'(w_b);
    assign w_rem   = r_plen - 16'd3 - 16'(w_b);

    always_comb begin
        n_phase = r_phase;
        n_code  = r_code;
        n_hidx  = r_hidx;
        n_skip  = r_skip;
        n_plen  = r_plen;
        n_frame = r_frame;
        n_count = r_count;
        n_halt  = r_halt;
        w_emit  = 1'b0;
        unique case (r_phase)
            PH_CODE: begin
                n_code = {r_code[23:0], w_b};
                n_hidx = r_hidx + 4'd1;
                if (r_hidx == HIDX_CODE_LAST) begin
                    if (n_code == SC_PACK) begin
                        n_frame = FRAME_P;
                        n_phase = PH_PACK;
                    end else if (n_code == SC_SYS || n_code == SC_MAP) begin
                        n_frame = FRAME_I;
                        n_phase = PH_LEN;
                    end else if (n_code == SC_VIDEO || n_code == SC_AUDIO) begin
                        n_phase = PH_PES;
                    end else begin
                        n_phase = PH_HALT;
                        n_halt  = STOP_UNKNOWN;
                    end
                end
            end
            PH_PACK: begin
                if (r_hidx == PACK_STUFF_POS) begin
                    if (w_stuff == 3'd0) begin
                        n_phase = PH_CODE;
                        n_hidx  = 4'd0;
                    end else begin
                        n_phase = PH_SKIP;
                        n_skip  = 16'(w_stuff);
                    end
                end else begin
                    n_hidx = r_hidx + 4'd1;
                end
            end
            PH_LEN: begin
                if (r_hidx == HIDX_LEN_HI) begin
                    n_plen = {w_b, 8'h00};
                    n_hidx = HIDX_LEN_LO;
                end else begin
                    n_plen = {r_plen[15:8], w_b};
                    if (n_plen == 16'd0) begin
                        n_phase = PH_CODE;
                        n_hidx  = 4'd0;
                    end else begin
                        n_phase = PH_SKIP;
                        n_skip  = n_plen;
                    end
                end
            end
            PH_PES: begin
                n_hidx = r_hidx + 4'd1;
                if (r_hidx == HIDX_LEN_HI) begin
                    n_plen = {w_b, 8'h00};
                end else if (r_hidx == HIDX_LEN_LO) begin
                    n_plen = {r_plen[15:8], w_b};
                end else if (r_hidx == HIDX_HDR_LEN) begin
                    n_hidx = r_hidx;
                    if ({1'b0, r_plen} < w_need) begin
                        n_phase = PH_HALT;
                        n_halt  = STOP_BAD_LEN;
                    end else begin
                        n_plen = w_rem;
                        if (w_b != 8'd0) begin
                            n_phase = PH_HSKIP;
                            n_skip  = 16'(w_b);
                        end else if (w_rem == 16'd0) begin
                            n_phase = PH_CODE;
                            n_hidx  = 4'd0;
                        end else begin
                            n_phase = (r_code == SC_VIDEO) ? PH_PAY : PH_SKIP;
                            n_skip  = w_rem;
                        end
                    end
                end
            end
            PH_HSKIP: begin
                n_skip = r_skip - 16'd1;
                if (n_skip == 16'd0) begin
                    if (r_plen == 16'd0) begin
                        n_phase = PH_CODE;
                        n_hidx  = 4'd0;
                    end else begin
                        n_phase = (r_code == SC_VIDEO) ? PH_PAY : PH_SKIP;
                        n_skip  = r_plen;
                    end
                end
            end
            PH_PAY: begin
                w_emit = 1'b1;
                if (r_count != {COUNT_BITS{1'b1}}) begin
                    n_count = r_count + COUNT_BITS'(1);
                end
                n_skip = r_skip - 16'd1;
                if (n_skip == 16'd0) begin
                    n_phase = PH_CODE;
                    n_hidx  = 4'd0;
                end
            end
            PH_SKIP: begin
                n_skip = r_skip - 16'd1;
                if (n_skip == 16'd0) begin
                    n_phase = PH_CODE;
                    n_hidx  = 4'd0;
                end
            end
            PH_HALT: begin
                n_phase = PH_HALT;
            end
            default: begin
                n_phase = PH_CODE;
                n_hidx  = 4'd0;
            end
        endcase
    end

    assign o_produce            = (r_phase == PH_PAY) || i_word.last_byte;
    assign o_result.out_byte    = w_emit ? w_b : 8'd0;
    assign o_result.out_valid   = w_emit;
    assign o_result.done_res    = i_word.last_byte;
    assign o_result.frame_type  = n_frame;
    assign o_result.body_length = 24'(n_count);
    assign o_result.stop_status = n_halt;

    // The last byte of a buffer returns every field to its reset value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_word.last_byte)) begin
            r_phase <= PH_CODE;
            r_code  <= '0;
            r_hidx  <= '0;
            r_skip  <= '0;
            r_plen  <= '0;
            r_frame <= FRAME_NONE;
            r_count <= '0;
            r_halt  <= STOP_NONE;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_code  <= n_code;
            r_hidx  <= n_hidx;
            r_skip  <= n_skip;
            r_plen  <= n_plen;
            r_frame <= n_frame;
            r_count <= n_count;
            r_halt  <= n_halt;
        end
    end

endmodule

FILE: rtl/pse_out_stage.sv
// Result register of the program stream extractor with valid/ready output.
// Depends on pse_pkg.
module pse_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  pse_pkg::t_out_word i_word,
    output logic               o_free,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pse_pkg::t_out_word o_out_data
);
    import pse_pkg::*;

    logic      r_valid;
    t_out_word r_data;

    // Slot frees up in the same cycle the held word leaves.
    assign o_free      = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_data <= i_word;
        end
    end

endmodule

FILE: rtl/program_stream_video_extractor.sv
// Program stream video extractor: top level with input register, parser, result register.
// Path: an accepted word is held in the input register, and its parser result is loaded into the result register.
// Throughput: one input word per cycle; the result register alone can stall the input.
// Reset: i_rst_n, synchronous, active low, clears parse state and both valid flags.
// Depends on pse_pkg, pse_parser and pse_out_stage.
module program_stream_video_extractor (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pse_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pse_pkg::t_out_word o_out_data
);
    import pse_pkg::*;

    // Input register: holds one stream word ahead of the parser.
    logic      r_in_valid;
    t_in_word  r_in_word;

    logic      w_produce;
    logic      w_out_free;
    logic      w_advance;
    t_out_word w_result;

    // Advance the held word into the parser when it makes no result, or when
    // the result register can take the result it makes.
    assign w_advance  = r_in_valid && (!w_produce || w_out_free);
    // Take a new word whenever the input register is empty or drains this cycle.
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Payload needs no reset: it is qualified by r_in_valid.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_data;
        end
    end

    // Parser: one byte per step, updates phase, counters and status.
    pse_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_advance),
        .i_word    (r_in_word),
        .o_produce (w_produce),
        .o_result  (w_result)
    );

    // Result register toward the consumer.
    pse_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_advance && w_produce),
        .i_word      (w_result),
        .o_free      (w_out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Every result word carries a payload byte or closes a buffer.
    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.out_valid || o_out_data.done_res))
        else $error("result word with neither payload nor end of buffer");

    // A word without payload shows a zero byte.
    a_idle_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.out_valid) |-> (o_out_data.out_byte == 8'd0))
        else $error("nonzero byte on a word without payload");

    // A held input word that cannot advance stays in the input register.
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_word)))
        else $error("stalled input word lost");

    // Frame type and stop status never take the unused code.
    a_codes_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.frame_type <= FRAME_I &&
                         o_out_data.stop_status <= STOP_BAD_LEN))
        else $error("illegal frame type or stop status");

endmodule
